// ----- design/evs_pkg.sv -----
`default_nettype none
package evs_pkg;

   localparam int MAX_ENTRIES = 1024;
   localparam int POS_W       = (MAX_ENTRIES > 2) ? $clog2(MAX_ENTRIES) : 1;
   localparam int INDEX_W     = 10;
   localparam int SEC_W       = 32;
   localparam int NANO_W      = 30;
   localparam int COUNT_W     = 32;
   localparam int SIZE_W      = 32;
   localparam int MODE_W      = 2;

   localparam int REQ_DATA_W  = 192;
   localparam int RSP_DATA_W  = 48;

   localparam logic [MODE_W-1:0] MODE_FIFO = 2'd0;
   localparam logic [MODE_W-1:0] MODE_LRU  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_LFU  = 2'd2;
   localparam logic [MODE_W-1:0] MODE_MFU  = 2'd3;

   typedef struct packed {
      logic [SEC_W-1:0]   created_seconds;
      logic [NANO_W-1:0]  created_nanos;
      logic [SEC_W-1:0]   used_seconds;
      logic [NANO_W-1:0]  used_nanos;
      logic [COUNT_W-1:0] use_count;
      logic [SIZE_W-1:0]  entry_size;
      logic               may_evict;
      logic               final_entry;
   } req_item_type;

   typedef struct packed {
      logic               victim_found;
      logic [INDEX_W-1:0] victim_index;
      logic [SIZE_W-1:0]  victim_size;
   } rsp_item_type;

endpackage
`default_nettype wire

// ----- design/eviction_victim_selector.sv -----
// rsp_tvalid rises once the request that ends the scan has passed the input register and then the result register.
// Throughput: one request per cycle; the result register lets the next scan start
// while a result waits. A stalled result holds only a final request behind it.
// Reset (synchronous): policy returns to FIFO, the scan state clears and both
// the input and result registers empty; no request is taken while reset is high.
`default_nettype none
module eviction_victim_selector (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                csr_valid,
   output logic                               csr_ready,
   input  wire  [evs_pkg::MODE_W-1:0]         csr_data,      // policy_mode
   input  wire                                req_tvalid,
   output logic                               req_tready,
   // created_seconds, created_nanos, used_seconds, used_nanos, use_count, entry_size
   input  wire  [evs_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  wire                                req_tuser,     // may_evict
   input  wire                                req_tlast,     // final_entry
   output logic                               rsp_tvalid,
   input  wire                                rsp_tready,
   output logic [evs_pkg::RSP_DATA_W-1:0]     rsp_tdata,     // victim_index, victim_size
   output logic                               rsp_tuser      // victim_found
);
   import evs_pkg::*;

   logic [MODE_W-1:0] policy_ff;
   logic              stage_valid_ff;
   req_item_type      stage_ff, stage_in;
   logic              rsp_valid_ff;
   rsp_item_type      rsp_ff;
   rsp_item_type      scan_result;
   logic              out_free;
   logic              stage_go;

   assign csr_ready = !reset;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign stage_go   = stage_valid_ff && (!stage_ff.final_entry || out_free);
   assign req_tready = !reset && (!stage_valid_ff || stage_go);

   always_comb begin
      stage_in.created_seconds = req_tdata[31:0];
      stage_in.created_nanos   = req_tdata[61:32];
      stage_in.used_seconds    = req_tdata[93:62];
      stage_in.used_nanos      = req_tdata[123:94];
      stage_in.use_count       = req_tdata[155:124];
      stage_in.entry_size      = req_tdata[187:156];
      stage_in.may_evict       = req_tuser;
      stage_in.final_entry     = req_tlast;
   end

   evs_scan u_scan (
      .clock       (clock),
      .reset       (reset),
      .policy_mode (policy_ff),
      .item_go     (stage_go),
      .item        (stage_ff),
      .result      (scan_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff      <= MODE_FIFO;
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            policy_ff <= csr_data;
         end
         if (req_tready) begin
            stage_valid_ff <= req_tvalid;
         end
         if (stage_go && stage_ff.final_entry) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         stage_ff <= stage_in;
      end
      if (stage_go && stage_ff.final_entry) begin
         rsp_ff <= scan_result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.victim_found;
   assign rsp_tdata  = {{(RSP_DATA_W - INDEX_W - SIZE_W){1'b0}},
                        rsp_ff.victim_size, rsp_ff.victim_index};

   // no victim means an all-zero result
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.victim_found |-> rsp_ff.victim_index == '0 &&
                                               rsp_ff.victim_size == '0)
      else $error("empty result carries nonzero fields");

   // a final request never overruns a waiting result
   a_final_holds: assert property (@(posedge clock) disable iff (reset)
      stage_valid_ff && stage_ff.final_entry && rsp_valid_ff && !rsp_tready |-> !req_tready)
      else $error("final request passed a stalled result");

   // a new result only follows a completed scan
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(stage_go && stage_ff.final_entry))
      else $error("result without a final request");

endmodule
`default_nettype wire

// ----- design/evs_scan.sv -----
`default_nettype none
module evs_scan (
   input  wire                           clock,
   input  wire                           reset,
   input  wire  [evs_pkg::MODE_W-1:0]    policy_mode,
   input  wire                           item_go,
   input  evs_pkg::req_item_type         item,
   output evs_pkg::rsp_item_type         result
);
   import evs_pkg::*;

   logic               best_valid_ff, best_valid_in;
   logic [SEC_W-1:0]   best_sec_ff, best_sec_in;
   logic [NANO_W-1:0]  best_nano_ff, best_nano_in;
   logic [COUNT_W-1:0] best_count_ff, best_count_in;
   logic [SIZE_W-1:0]  best_size_ff, best_size_in;
   logic [POS_W-1:0]   best_pos_ff, best_pos_in;
   logic [POS_W-1:0]   scan_pos_ff, scan_pos_in;

   logic [SEC_W-1:0]   key_sec;
   logic [NANO_W-1:0]  key_nano;
   logic               eligible;
   logic               earlier;
   logic               take;

   assign key_sec  = (policy_mode == MODE_FIFO) ? item.created_seconds : item.used_seconds;
   assign key_nano = (policy_mode == MODE_FIFO) ? item.created_nanos   : item.used_nanos;
   assign eligible = (item.entry_size != '0) && item.may_evict;
   assign earlier  = (key_sec < best_sec_ff) ||
                     ((key_sec == best_sec_ff) && (key_nano < best_nano_ff));

   always_comb begin
      if (!best_valid_ff) begin
         take = 1'b1;
      end else begin
         case (policy_mode) inside
            MODE_FIFO, MODE_LRU: take = earlier;
            MODE_LFU:            take = item.use_count < best_count_ff;
            default:             take = item.use_count > best_count_ff;
         endcase
      end
   end

   // best candidate after this entry
   always_comb begin
      best_valid_in = best_valid_ff;
      best_sec_in   = best_sec_ff;
      best_nano_in  = best_nano_ff;
      best_count_in = best_count_ff;
      best_size_in  = best_size_ff;
      best_pos_in   = best_pos_ff;
      if (eligible && take) begin
         best_valid_in = 1'b1;
         best_sec_in   = key_sec;
         best_nano_in  = key_nano;
         best_count_in = item.use_count;
         best_size_in  = item.entry_size;
         best_pos_in   = scan_pos_ff;
      end
   end

   always_comb begin
      if (scan_pos_ff == POS_W'(MAX_ENTRIES - 1)) begin
         scan_pos_in = '0;
      end else begin
         scan_pos_in = scan_pos_ff + POS_W'(1);
      end
   end

   assign result.victim_found = best_valid_in;
   assign result.victim_index = best_valid_in ? INDEX_W'(best_pos_in) : '0;
   assign result.victim_size  = best_valid_in ? best_size_in : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         best_valid_ff <= 1'b0;
         best_pos_ff   <= '0;
         scan_pos_ff   <= '0;
      end else if (item_go) begin
         if (item.final_entry) begin
            best_valid_ff <= 1'b0;
            best_pos_ff   <= '0;
            scan_pos_ff   <= '0;
         end else begin
            best_valid_ff <= best_valid_in;
            best_pos_ff   <= best_pos_in;
            scan_pos_ff   <= scan_pos_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (item_go) begin
         best_sec_ff   <= best_sec_in;
         best_nano_ff  <= best_nano_in;
         best_count_ff <= best_count_in;
         best_size_ff  <= best_size_in;
      end
   end

endmodule
`default_nettype wire
